FILE: hw/rtl/lfrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrm_pkg: shared types and constants of the flash rate monitor
// Register indexes, reset values, field widths and the tick word passed
// from the top level to the timestamp window.
// ----------------------------------------------------------------------------
package lfrm_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 9;
    localparam int DEFAULT_LED_BITS     = 16;

    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;
    localparam int ENTER_W     = 4;
    localparam int COUNT_OUT_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FLASH_MS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_STEP_MS  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTER_COUNT  = 4'd3;

    localparam logic [MS_W-1:0]    RESET_MAX_FLASH_MS = 16'd500;
    localparam logic [MS_W-1:0]    RESET_WINDOW_MS    = 16'd3000;
    localparam logic [MS_W-1:0]    RESET_LED_STEP_MS  = 16'd250;
    localparam logic [ENTER_W-1:0] RESET_ENTER_COUNT  = 4'd4;

    typedef struct packed {
        logic              tick;
        logic              flash;
        logic [TIME_W-1:0] now;
    } win_req_t;

endpackage

FILE: hw/rtl/lfrm_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrm_window: circular window of flash timestamps
// Records flash end times, drops the oldest when full and expires at most
// one old entry per tick. The two oldest entries are read ahead each cycle.
// ----------------------------------------------------------------------------
module lfrm_window #(
    parameter int WINDOW_DEPTH = lfrm_pkg::DEFAULT_WINDOW_DEPTH,
    localparam int PW = $clog2(WINDOW_DEPTH),
    localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lfrm_pkg::win_req_t          req,
    input  logic [lfrm_pkg::MS_W-1:0]   window_ms,
    output logic [CW-1:0]               count_next
);

    localparam logic [PW-1:0] LAST_SLOT = PW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);
    localparam logic [CW:0]   DEPTH_SUM = (CW+1)'(WINDOW_DEPTH);

    logic [lfrm_pkg::TIME_W-1:0] mem [WINDOW_DEPTH];
    logic [lfrm_pkg::TIME_W-1:0] rd0_reg;
    logic [lfrm_pkg::TIME_W-1:0] rd1_reg;
    logic [CW-1:0]               count_reg;
    logic [PW-1:0]               oldest_reg;
    logic [PW-1:0]               oldest_next;

    logic                        full;
    logic                        empty;
    logic                        we;
    logic [CW:0]                 wsum;
    logic [PW-1:0]               waddr;
    logic [PW-1:0]               oldest1;
    logic [CW-1:0]               count1;
    logic [lfrm_pkg::TIME_W-1:0] head;
    logic [lfrm_pkg::TIME_W-1:0] age;
    logic                        expire;
    logic [PW-1:0]               ra0;
    logic [PW-1:0]               ra1;

    function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        full  = (count_reg == FULL_CNT);
        empty = (count_reg == '0);
        we    = req.tick && req.flash;

        wsum  = (CW+1)'(oldest_reg) + (CW+1)'(count_reg);
        if (full) begin
            waddr = oldest_reg;
        end else if (wsum >= DEPTH_SUM) begin
            waddr = PW'(wsum - DEPTH_SUM);
        end else begin
            waddr = PW'(wsum);
        end

        oldest1 = (req.flash && full) ? slot_inc(oldest_reg) : oldest_reg;
        count1  = (req.flash && !full) ? count_reg + CW'(1) : count_reg;

        if (req.flash && empty) begin
            head = req.now;
        end else if (req.flash && full) begin
            head = rd1_reg;
        end else begin
            head = rd0_reg;
        end

        age    = req.now - head;
        expire = (count1 != '0) &&
                 (age > lfrm_pkg::TIME_W'(window_ms));

        if (req.tick) begin
            oldest_next = expire ? slot_inc(oldest1) : oldest1;
            count_next  = expire ? count1 - CW'(1) : count1;
        end else begin
            oldest_next = oldest_reg;
            count_next  = count_reg;
        end

        ra0 = oldest_next;
        ra1 = slot_inc(oldest_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            oldest_reg <= '0;
        end else begin
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
        end
    end

    // read-ahead of the two oldest slots, write-first on a collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= req.now;
        end
        rd0_reg <= (we && waddr == ra0) ? req.now : mem[ra0];
        rd1_reg <= (we && waddr == ra1) ? req.now : mem[ra1];
    end

endmodule

FILE: hw/rtl/lightning_flash_rate_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lightning_flash_rate_monitor: flash rate monitor with survival countdown
// Each input word is one millisecond tick carrying a threshold crossing flag.
// Channels: s_valid/s_ready/s_crossing in, m_valid/m_ready and five result
// fields out, cfg_valid/cfg_ready/cfg_index/cfg_data for register writes
// (0 max_flash_ms, 1 window_ms, 2 led_step_ms, 3 enter_count; others
// ignored). cfg_ready is high out of reset; write only while the block is idle.
// Every tick yields exactly one result word, registered in the cycle after
// the tick is accepted. One tick per cycle is sustained: the timestamp
// window reads its two oldest slots ahead, so each tick is a single pass
// of compare and update logic into the state and the output register.
// When the receiver stalls, the output register holds its word and s_ready
// stays high only if that word is taken in the same cycle.
// Reset (aresetn low, synchronous) holds s_ready and cfg_ready low, restores
// the register defaults, clears the time, pulse and window state, and starts
// in survival mode with a full pattern; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lightning_flash_rate_monitor #(
    parameter int WINDOW_DEPTH = lfrm_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int LED_BITS     = lfrm_pkg::DEFAULT_LED_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_crossing,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_mode,
    output logic [lfrm_pkg::COUNT_OUT_W-1:0]    m_flash_count,
    output logic [LED_BITS-1:0]                 m_led_pattern,
    output logic                                m_flash_detected,
    output logic                                m_mode_changed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfrm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [LED_BITS-1:0] BAR_ONES = {LED_BITS{1'b1}};

    logic [lfrm_pkg::MS_W-1:0]    max_flash_reg;
    logic [lfrm_pkg::MS_W-1:0]    window_ms_reg;
    logic [lfrm_pkg::MS_W-1:0]    led_step_reg;
    logic [lfrm_pkg::ENTER_W-1:0] enter_count_reg;

    logic [lfrm_pkg::TIME_W-1:0]  ms_time_reg;
    logic [lfrm_pkg::TIME_W-1:0]  ms_time_next;
    logic [lfrm_pkg::TIME_W-1:0]  pulse_start_reg;
    logic [lfrm_pkg::TIME_W-1:0]  pulse_start_next;
    logic                         above_reg;
    logic                         above_next;
    logic                         survival_reg;
    logic                         survival_next;
    logic [LED_BITS-1:0]          bar_reg;
    logic [LED_BITS-1:0]          bar_next;
    logic [lfrm_pkg::MS_W-1:0]    step_reg;
    logic [lfrm_pkg::MS_W-1:0]    step_next;
    logic [lfrm_pkg::MS_W-1:0]    step_inc;

    logic                         m_valid_reg;
    logic                         m_mode_reg;
    logic [lfrm_pkg::COUNT_OUT_W-1:0] m_count_reg;
    logic [LED_BITS-1:0]          m_pattern_reg;
    logic                         m_flash_reg;
    logic                         m_changed_reg;

    logic                         accept;
    logic                         flash;
    logic                         refill;
    logic [lfrm_pkg::TIME_W-1:0]  pulse_len;
    logic [CW-1:0]                count_next;
    lfrm_pkg::win_req_t           win_req;

    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = aresetn;

    assign m_valid          = m_valid_reg;
    assign m_mode           = m_mode_reg;
    assign m_flash_count    = m_count_reg;
    assign m_led_pattern    = m_pattern_reg;
    assign m_flash_detected = m_flash_reg;
    assign m_mode_changed   = m_changed_reg;

    always_comb begin
        ms_time_next     = ms_time_reg + lfrm_pkg::TIME_W'(1);
        pulse_start_next = pulse_start_reg;
        above_next       = above_reg;
        flash            = 1'b0;
        refill           = 1'b0;
        pulse_len        = ms_time_next - pulse_start_reg;

        if (s_crossing) begin
            if (above_reg) begin
                flash      = (pulse_len < lfrm_pkg::TIME_W'(max_flash_reg));
                above_next = 1'b0;
            end else begin
                pulse_start_next = ms_time_next;
                refill           = survival_reg;
                above_next       = 1'b1;
            end
        end

        win_req.tick  = accept;
        win_req.flash = flash;
        win_req.now   = ms_time_next;

        survival_next = survival_reg;
        bar_next      = bar_reg;
        step_next     = step_reg;
        step_inc      = step_reg + lfrm_pkg::MS_W'(1);

        if (survival_reg) begin
            if (refill) begin
                bar_next  = BAR_ONES;
                step_next = '0;
            end else if (step_inc >= led_step_reg) begin
                step_next = '0;
                bar_next  = bar_reg >> 1;
            end else begin
                step_next = step_inc;
            end
            if (bar_next == '0) begin
                survival_next = 1'b0;
            end
        end else if (32'(count_next) >= 32'(enter_count_reg)) begin
            survival_next = 1'b1;
            bar_next      = BAR_ONES;
            step_next     = '0;
        end
    end

    lfrm_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (win_req),
        .window_ms (window_ms_reg),
        .count_next(count_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_flash_reg   <= lfrm_pkg::RESET_MAX_FLASH_MS;
            window_ms_reg   <= lfrm_pkg::RESET_WINDOW_MS;
            led_step_reg    <= lfrm_pkg::RESET_LED_STEP_MS;
            enter_count_reg <= lfrm_pkg::RESET_ENTER_COUNT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lfrm_pkg::REG_MAX_FLASH_MS: max_flash_reg <= cfg_data;
                lfrm_pkg::REG_WINDOW_MS:    window_ms_reg <= cfg_data;
                lfrm_pkg::REG_LED_STEP_MS:  led_step_reg  <= cfg_data;
                lfrm_pkg::REG_ENTER_COUNT:  begin
                    enter_count_reg <= cfg_data[lfrm_pkg::ENTER_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_time_reg     <= '0;
            pulse_start_reg <= '0;
            above_reg       <= 1'b0;
            survival_reg    <= 1'b1;
            bar_reg         <= BAR_ONES;
            step_reg        <= '0;
        end else if (accept) begin
            ms_time_reg     <= ms_time_next;
            pulse_start_reg <= pulse_start_next;
            above_reg       <= above_next;
            survival_reg    <= survival_next;
            bar_reg         <= bar_next;
            step_reg        <= step_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_mode_reg    <= survival_next;
            m_count_reg   <= lfrm_pkg::COUNT_OUT_W'(count_next);
            m_pattern_reg <= bar_next;
            m_flash_reg   <= flash;
            m_changed_reg <= (survival_next != survival_reg);
        end
    end

endmodule
